>>> sv/cste_pkg.sv
// ----------------------------------------------------------------------------
// cste_pkg
// Shared types and codes of the scheduling timing engine.
// ----------------------------------------------------------------------------
package cste_pkg;

   localparam int ARR_W  = 16;
   localparam int BUR_W  = 16;
   localparam int PRI_W  = 8;
   localparam int QNT_W  = 16;
   localparam int MODE_W = 2;

   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 72;
   localparam int PIDX_W     = 4;
   localparam int CT_W       = 21;
   localparam int WT_W       = 20;
   localparam int TAT_W      = 21;

   localparam logic [MODE_W-1:0] MODE_FCFS = 2'd0;
   localparam logic [MODE_W-1:0] MODE_SRTF = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PRIO = 2'd2;
   localparam logic [MODE_W-1:0] MODE_RR   = 2'd3;

   localparam logic CSR_POLICY  = 1'b0;
   localparam logic CSR_QUANTUM = 1'b1;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_INIT,
      OP_CLEAR,
      OP_SCAN_START,
      OP_SCAN_STEP,
      OP_TAKE_A,
      OP_TAKE_B,
      OP_JUMP_A,
      OP_JUMP_N,
      OP_POP,
      OP_FETCH,
      OP_ADVANCE,
      OP_PUSH_A,
      OP_PUSH_RUN,
      OP_FINISH
   } op_type;

   typedef enum logic [1:0] {
      SCAN_UNFIN,
      SCAN_ADMIT,
      SCAN_UNADM
   } scan_type;

   typedef struct packed {
      op_type   op;
      scan_type kind;
      logic     load;
   } cmd_type;

   typedef struct packed {
      logic [MODE_W-1:0] mode;
      logic              scan_last;
      logic              a_vld;
      logic              b_vld;
      logic              q_empty;
      logic              run_done;
      logic              out_free;
      logic              last_one;
   } status_type;

endpackage

>>> sv/cpu_schedule_timing_engine.sv
// ----------------------------------------------------------------------------
// cpu_schedule_timing_engine
// Process scheduling simulator: FCFS, shortest remaining time, priority and
// round robin, one completion result per loaded process.
// ----------------------------------------------------------------------------
// Records load one per cycle while no run is in progress. The record flagged
// with tlast starts a run and the request side then stalls until the run is
// over. Every pick of the next process sweeps the record store one entry per
// cycle; a completed pick then advances time and emits its result, and a jump
// over an idle gap costs one more sweep. A round robin slice adds one further
// sweep for each process it admits to the ready queue, and emits a result if
// the process finishes. Shortest remaining time sweeps again each time an
// arrival cuts the running burst short. The last result of a run may still
// wait in the output register while the next batch loads. Registers may be
// written only between runs.
module cpu_schedule_timing_engine #(
   parameter int MAX_PROCS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // arrival_time[15:0], burst_time[31:16], priority_level[39:32]
   input  logic [39:0] req_tdata,
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // process_index[3:0], completion_time[24:4], waiting_time[44:25],
   // turnaround_time[65:45], zero fill[71:66]
   output logic [71:0] rsp_tdata,
   output logic        rsp_tlast,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wr_data
);

   cste_pkg::cmd_type    cmd;
   cste_pkg::status_type st;

   cste_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   cste_dp #(.MAX_PROCS(MAX_PROCS)) u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .st          (st),
      .in_arr      (req_tdata[15:0]),
      .in_bur      (req_tdata[31:16]),
      .in_pri      (req_tdata[39:32]),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast)
   );

endmodule

>>> sv/cste_ctrl.sv
// ----------------------------------------------------------------------------
// cste_ctrl
// Sequencer: loads records, then steps the selected policy through scans,
// picks, time advances and result emission.
// ----------------------------------------------------------------------------
module cste_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   input  cste_pkg::status_type st,
   output cste_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      S_LOAD, S_INIT, S_SCAN_START, S_SCAN, S_EVAL, S_RUN, S_CHECK, S_FINISH,
      S_DONE, S_ADM_START, S_ADM_SCAN, S_ADM_EVAL, S_RR_NEXT, S_FETCH
   } state_type;

   state_type state_ff, state_in;
   logic      pend_ff, pend_in;
   logic      accept;

   assign req_tready = (state_ff == S_LOAD);
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd.op   = cste_pkg::OP_NONE;
      cmd.kind = cste_pkg::SCAN_UNFIN;
      cmd.load = accept;
      unique case (state_ff)
         S_LOAD: begin
            if (accept && req_tlast) state_in = S_INIT;
         end
         S_INIT: begin
            cmd.op  = cste_pkg::OP_INIT;
            pend_in = 1'b0;
            state_in = (st.mode == cste_pkg::MODE_RR) ? S_ADM_START : S_SCAN_START;
         end
         S_SCAN_START: begin
            cmd.op   = cste_pkg::OP_SCAN_START;
            cmd.kind = (st.mode == cste_pkg::MODE_RR) ? cste_pkg::SCAN_UNADM
                                                      : cste_pkg::SCAN_UNFIN;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.op = cste_pkg::OP_SCAN_STEP;
            if (st.scan_last) state_in = S_EVAL;
         end
         S_EVAL: begin
            unique case (st.mode)
               cste_pkg::MODE_FCFS: begin
                  cmd.op   = cste_pkg::OP_TAKE_A;
                  state_in = S_RUN;
               end
               cste_pkg::MODE_PRIO: begin
                  cmd.op   = st.b_vld ? cste_pkg::OP_TAKE_B : cste_pkg::OP_JUMP_A;
                  state_in = st.b_vld ? S_RUN : S_SCAN_START;
               end
               cste_pkg::MODE_SRTF: begin
                  cmd.op   = st.b_vld ? cste_pkg::OP_TAKE_B : cste_pkg::OP_JUMP_N;
                  state_in = st.b_vld ? S_RUN : S_SCAN_START;
               end
               default: begin
                  cmd.op   = cste_pkg::OP_JUMP_A;
                  state_in = S_ADM_START;
               end
            endcase
         end
         S_RUN: begin
            cmd.op   = cste_pkg::OP_ADVANCE;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (st.mode == cste_pkg::MODE_RR) begin
               pend_in  = 1'b1;
               state_in = S_ADM_START;
            end else begin
               state_in = st.run_done ? S_FINISH : S_SCAN_START;
            end
         end
         S_FINISH: begin
            if (st.out_free) begin
               cmd.op  = cste_pkg::OP_FINISH;
               pend_in = 1'b0;
               if (st.last_one) state_in = S_DONE;
               else if (st.mode == cste_pkg::MODE_RR) state_in = S_RR_NEXT;
               else state_in = S_SCAN_START;
            end
         end
         S_DONE: begin
            cmd.op   = cste_pkg::OP_CLEAR;
            state_in = S_LOAD;
         end
         S_ADM_START: begin
            cmd.op   = cste_pkg::OP_SCAN_START;
            cmd.kind = cste_pkg::SCAN_ADMIT;
            state_in = S_ADM_SCAN;
         end
         S_ADM_SCAN: begin
            cmd.op = cste_pkg::OP_SCAN_STEP;
            if (st.scan_last) state_in = S_ADM_EVAL;
         end
         S_ADM_EVAL: begin
            // Newly arrived processes enter the queue before the preempted one.
            if (st.a_vld) begin
               cmd.op   = cste_pkg::OP_PUSH_A;
               state_in = S_ADM_START;
            end else if (pend_ff && st.run_done) begin
               state_in = S_FINISH;
            end else if (pend_ff) begin
               cmd.op   = cste_pkg::OP_PUSH_RUN;
               pend_in  = 1'b0;
               state_in = S_RR_NEXT;
            end else begin
               state_in = S_RR_NEXT;
            end
         end
         S_RR_NEXT: begin
            if (st.q_empty) begin
               state_in = S_SCAN_START;
            end else begin
               cmd.op   = cste_pkg::OP_POP;
               state_in = S_FETCH;
            end
         end
         S_FETCH: begin
            cmd.op   = cste_pkg::OP_FETCH;
            state_in = S_RUN;
         end
         default: state_in = S_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

>>> sv/cste_dp.sv
// ----------------------------------------------------------------------------
// cste_dp
// Datapath: record stores, ready queue, candidate search, simulated time
// and the result register.
// ----------------------------------------------------------------------------
module cste_dp #(
   parameter int MAX_PROCS = 16
) (
   input  logic                                clock,
   input  logic                                reset,
   input  cste_pkg::cmd_type                   cmd,
   output cste_pkg::status_type                st,
   input  logic [cste_pkg::ARR_W-1:0]          in_arr,
   input  logic [cste_pkg::BUR_W-1:0]          in_bur,
   input  logic [cste_pkg::PRI_W-1:0]          in_pri,
   input  logic                                csr_wr_en,
   input  logic                                csr_index,
   input  logic [cste_pkg::QNT_W-1:0]          csr_wr_data,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [cste_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast
);

   localparam int IDX_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
   localparam int CNT_W  = $clog2(MAX_PROCS + 1);
   localparam int TIME_W = $clog2(65535 * (MAX_PROCS + 1) + 1);
   localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(MAX_PROCS - 1);

   logic [cste_pkg::ARR_W-1:0] arr_mem [MAX_PROCS];
   logic [cste_pkg::BUR_W-1:0] bur_mem [MAX_PROCS];
   logic [cste_pkg::PRI_W-1:0] pri_mem [MAX_PROCS];
   logic [cste_pkg::BUR_W-1:0] rem_mem [MAX_PROCS];
   logic [IDX_W-1:0]           q_mem   [MAX_PROCS];

   logic [cste_pkg::MODE_W-1:0] mode_ff;
   logic [cste_pkg::QNT_W-1:0]  quantum_ff;
   logic [CNT_W-1:0]  load_cnt_ff, emit_cnt_ff, q_cnt_ff;
   logic [IDX_W-1:0]  q_head_ff, q_tail_ff, scan_ff, run_idx_ff;
   logic [TIME_W-1:0] time_ff;
   logic [MAX_PROCS-1:0] done_ff, adm_ff;
   cste_pkg::scan_type kind_ff;

   logic                       a_vld_ff, b_vld_ff, n_vld_ff;
   logic [IDX_W-1:0]           a_idx_ff, b_idx_ff;
   logic [cste_pkg::ARR_W-1:0] a_arr_ff, b_arr_ff, n_arr_ff, run_arr_ff;
   logic [cste_pkg::BUR_W-1:0] a_bur_ff, b_bur_ff, a_rem_ff, b_rem_ff;
   logic [cste_pkg::BUR_W-1:0] run_bur_ff, run_rem_ff;
   logic [cste_pkg::PRI_W-1:0] b_pri_ff;

   logic                        rsp_vld_ff;
   logic [cste_pkg::RSP_DATA_W-1:0] rsp_data_ff;
   logic                        rsp_last_ff;

   logic [IDX_W-1:0]           rd_addr;
   logic [cste_pkg::ARR_W-1:0] rd_arr;
   logic [cste_pkg::BUR_W-1:0] rd_bur, rd_rem;
   logic [cste_pkg::PRI_W-1:0] rd_pri;
   logic arrived, fa, fb, better;
   logic [cste_pkg::BUR_W-1:0] load_bur;
   logic [TIME_W-1:0] base, lim, run_rem_ext, d, tat, wt;
   logic [cste_pkg::BUR_W-1:0] d16, rem_new;
   logic [cste_pkg::QNT_W-1:0] q_eff;
   logic [CNT_W-1:0] emit_next;

   assign rd_addr = (cmd.op == cste_pkg::OP_FETCH) ? run_idx_ff : scan_ff;
   assign rd_arr  = arr_mem[rd_addr];
   assign rd_bur  = bur_mem[rd_addr];
   assign rd_rem  = rem_mem[rd_addr];
   assign rd_pri  = pri_mem[rd_addr];

   assign arrived = TIME_W'(rd_arr) <= time_ff;
   assign load_bur = (in_bur == '0) ? cste_pkg::BUR_W'(1) : in_bur;
   assign q_eff = (quantum_ff == '0) ? cste_pkg::QNT_W'(1) : quantum_ff;

   always_comb begin
      unique case (kind_ff)
         cste_pkg::SCAN_ADMIT: fa = !adm_ff[scan_ff] && arrived;
         cste_pkg::SCAN_UNADM: fa = !adm_ff[scan_ff];
         default:              fa = !done_ff[scan_ff];
      endcase
      fb = !done_ff[scan_ff] && arrived;
      // Ties fall to the earlier arrival; the scan runs in load order.
      if (mode_ff == cste_pkg::MODE_PRIO)
         better = !b_vld_ff || (rd_pri > b_pri_ff) ||
                  ((rd_pri == b_pri_ff) && (rd_arr < b_arr_ff));
      else
         better = !b_vld_ff || (rd_rem < b_rem_ff) ||
                  ((rd_rem == b_rem_ff) && (rd_arr < b_arr_ff));
   end

   always_comb begin
      run_rem_ext = TIME_W'(run_rem_ff);
      base = (time_ff > TIME_W'(run_arr_ff)) ? time_ff : TIME_W'(run_arr_ff);
      unique case (mode_ff)
         cste_pkg::MODE_SRTF: lim = n_vld_ff ? TIME_W'(n_arr_ff) - time_ff : '1;
         cste_pkg::MODE_RR:   lim = TIME_W'(q_eff);
         default:             lim = run_rem_ext;
      endcase
      d       = (lim < run_rem_ext) ? lim : run_rem_ext;
      d16     = cste_pkg::BUR_W'(d);
      rem_new = run_rem_ff - d16;
      tat = (time_ff >= TIME_W'(run_arr_ff)) ? time_ff - TIME_W'(run_arr_ff) : '0;
      wt  = (tat >= TIME_W'(run_bur_ff)) ? tat - TIME_W'(run_bur_ff) : '0;
      emit_next = emit_cnt_ff + CNT_W'(1);
   end

   // Payload stores.
   always_ff @(posedge clock) begin
      if (cmd.load && (load_cnt_ff < CNT_W'(MAX_PROCS))) begin
         arr_mem[load_cnt_ff[IDX_W-1:0]] <= in_arr;
         bur_mem[load_cnt_ff[IDX_W-1:0]] <= load_bur;
         rem_mem[load_cnt_ff[IDX_W-1:0]] <= load_bur;
         pri_mem[load_cnt_ff[IDX_W-1:0]] <= in_pri;
      end else if (cmd.op == cste_pkg::OP_ADVANCE) begin
         rem_mem[run_idx_ff] <= rem_new;
      end
      if (cmd.op == cste_pkg::OP_PUSH_A)   q_mem[q_tail_ff] <= a_idx_ff;
      if (cmd.op == cste_pkg::OP_PUSH_RUN) q_mem[q_tail_ff] <= run_idx_ff;
   end

   // Candidate and run payload registers.
   always_ff @(posedge clock) begin
      unique case (cmd.op)
         cste_pkg::OP_SCAN_STEP: begin
            if (fa && (!a_vld_ff || rd_arr < a_arr_ff)) begin
               a_idx_ff <= scan_ff;
               a_arr_ff <= rd_arr;
               a_bur_ff <= rd_bur;
               a_rem_ff <= rd_rem;
            end
            if (fb && better) begin
               b_idx_ff <= scan_ff;
               b_arr_ff <= rd_arr;
               b_bur_ff <= rd_bur;
               b_rem_ff <= rd_rem;
               b_pri_ff <= rd_pri;
            end
            if (!arrived && (!n_vld_ff || rd_arr < n_arr_ff)) n_arr_ff <= rd_arr;
         end
         cste_pkg::OP_TAKE_A: begin
            run_idx_ff <= a_idx_ff;
            run_arr_ff <= a_arr_ff;
            run_bur_ff <= a_bur_ff;
            run_rem_ff <= a_rem_ff;
         end
         cste_pkg::OP_TAKE_B: begin
            run_idx_ff <= b_idx_ff;
            run_arr_ff <= b_arr_ff;
            run_bur_ff <= b_bur_ff;
            run_rem_ff <= b_rem_ff;
         end
         cste_pkg::OP_POP: run_idx_ff <= q_mem[q_head_ff];
         cste_pkg::OP_FETCH: begin
            run_arr_ff <= rd_arr;
            run_bur_ff <= rd_bur;
            run_rem_ff <= rd_rem;
         end
         cste_pkg::OP_ADVANCE: run_rem_ff <= rem_new;
         default: ;
      endcase
      if (cmd.op == cste_pkg::OP_FINISH) begin
         rsp_data_ff <= {6'd0, cste_pkg::TAT_W'(tat), cste_pkg::WT_W'(wt),
                         cste_pkg::CT_W'(time_ff), cste_pkg::PIDX_W'(run_idx_ff)};
         rsp_last_ff <= (emit_next == load_cnt_ff);
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= cste_pkg::MODE_FCFS;
         quantum_ff  <= cste_pkg::QNT_W'(1);
         load_cnt_ff <= '0;
         emit_cnt_ff <= '0;
         q_cnt_ff    <= '0;
         q_head_ff   <= '0;
         q_tail_ff   <= '0;
         scan_ff     <= '0;
         time_ff     <= '0;
         done_ff     <= '0;
         adm_ff      <= '0;
         kind_ff     <= cste_pkg::SCAN_UNFIN;
         a_vld_ff    <= 1'b0;
         b_vld_ff    <= 1'b0;
         n_vld_ff    <= 1'b0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            if (csr_index == cste_pkg::CSR_POLICY)
               mode_ff <= csr_wr_data[cste_pkg::MODE_W-1:0];
            else
               quantum_ff <= csr_wr_data;
         end
         if (cmd.load && (load_cnt_ff < CNT_W'(MAX_PROCS)))
            load_cnt_ff <= load_cnt_ff + CNT_W'(1);
         if (cmd.op == cste_pkg::OP_FINISH) rsp_vld_ff <= 1'b1;
         else if (rsp_vld_ff && rsp_tready) rsp_vld_ff <= 1'b0;
         unique case (cmd.op)
            cste_pkg::OP_INIT: begin
               time_ff     <= '0;
               done_ff     <= '0;
               adm_ff      <= '0;
               q_cnt_ff    <= '0;
               q_head_ff   <= '0;
               q_tail_ff   <= '0;
               emit_cnt_ff <= '0;
            end
            cste_pkg::OP_CLEAR: load_cnt_ff <= '0;
            cste_pkg::OP_SCAN_START: begin
               scan_ff  <= '0;
               kind_ff  <= cmd.kind;
               a_vld_ff <= 1'b0;
               b_vld_ff <= 1'b0;
               n_vld_ff <= 1'b0;
            end
            cste_pkg::OP_SCAN_STEP: begin
               scan_ff <= scan_ff + IDX_W'(1);
               if (fa) a_vld_ff <= 1'b1;
               if (fb) b_vld_ff <= 1'b1;
               if (!arrived) n_vld_ff <= 1'b1;
            end
            cste_pkg::OP_JUMP_A: time_ff <= TIME_W'(a_arr_ff);
            cste_pkg::OP_JUMP_N: time_ff <= TIME_W'(n_arr_ff);
            cste_pkg::OP_ADVANCE: time_ff <= base + d;
            cste_pkg::OP_POP: begin
               q_head_ff <= (q_head_ff == LAST_SLOT) ? '0 : q_head_ff + IDX_W'(1);
               q_cnt_ff  <= q_cnt_ff - CNT_W'(1);
            end
            cste_pkg::OP_PUSH_A, cste_pkg::OP_PUSH_RUN: begin
               q_tail_ff <= (q_tail_ff == LAST_SLOT) ? '0 : q_tail_ff + IDX_W'(1);
               q_cnt_ff  <= q_cnt_ff + CNT_W'(1);
               if (cmd.op == cste_pkg::OP_PUSH_A) adm_ff[a_idx_ff] <= 1'b1;
            end
            cste_pkg::OP_FINISH: begin
               done_ff[run_idx_ff] <= 1'b1;
               emit_cnt_ff <= emit_next;
            end
            default: ;
         endcase
      end
   end

   assign st.mode      = mode_ff;
   assign st.scan_last = (CNT_W'(scan_ff) + CNT_W'(1)) == load_cnt_ff;
   assign st.a_vld     = a_vld_ff;
   assign st.b_vld     = b_vld_ff;
   assign st.q_empty   = (q_cnt_ff == '0);
   assign st.run_done  = (run_rem_ff == '0);
   assign st.out_free  = !rsp_vld_ff || rsp_tready;
   assign st.last_one  = (emit_next == load_cnt_ff);

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

>>> sv/cste_checker.sv
// ----------------------------------------------------------------------------
// cste_checker
// Port-level checks of the scheduling timing engine.
// ----------------------------------------------------------------------------
module cste_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [71:0] rsp_tdata
);

   // A result that is not taken stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   // The final record of a batch stops further loading while the run goes.
   a_run_stall: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("request taken during a scheduling run");

   // Completion is never below turnaround, and turnaround never below waiting.
   a_time_order: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[24:4] >= rsp_tdata[65:45]) &&
                     (rsp_tdata[65:45] >= {1'b0, rsp_tdata[44:25]}))
      else $error("inconsistent result times");

endmodule

bind cpu_schedule_timing_engine cste_checker u_cste_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tlast  (req_tlast),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> test/cpu_schedule_timing_engine_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpu_schedule_timing_engine_test
// Self-checking bench for the scheduling timing engine. Batches of process
// records are streamed in under every policy and several time slices; each
// batch is replayed by an in-bench scheduler and every completion request is
// compared field by field against it.
// ----------------------------------------------------------------------------
module cpu_schedule_timing_engine_test;

   localparam int NPROC       = 16;
   localparam int TOTAL_ITEMS = 410;
   localparam int CYCLE_LIMIT = 20000000;
   localparam int SETTLE      = 40;
   localparam int EXP_DEPTH   = 64;
   localparam int MAX_ROWS    = 32;

   typedef struct {
      logic [cste_pkg::PIDX_W-1:0] pidx;
      logic [cste_pkg::CT_W-1:0]   ct;
      logic [cste_pkg::WT_W-1:0]   wt;
      logic [cste_pkg::TAT_W-1:0]  tat;
      logic                        last;
   } completion_type;

   typedef struct {
      bit                          set_cfg;
      logic [cste_pkg::MODE_W-1:0] mode;
      logic [cste_pkg::QNT_W-1:0]  qnt;
      logic [cste_pkg::ARR_W-1:0]  arr;
      logic [cste_pkg::BUR_W-1:0]  bur;
      logic [cste_pkg::PRI_W-1:0]  pri;
      bit                          last;
      bit                          typed;
      int                          ct, wt, tat;
   } row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic        req_tlast = 0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_wr_en = 0;
   logic        csr_index = cste_pkg::CSR_POLICY;
   logic [15:0] csr_wr_data = '0;

   cpu_schedule_timing_engine dut (.*);

   always #10 clock = ~clock;

   // Expected completions, written by the predictor and read by the monitor.
   completion_type exp_buf[EXP_DEPTH];
   int  exp_wr = 0;
   int  exp_rd = 0;
   int  errors = 0;
   int  cycles = 0;
   int  items_sent = 0;
   int  rsp_hold = 0;
   bit  hold_start = 0;
   bit  hold_seen = 0;
   bit  quiet = 0;

   // Scheduler state mirrored from the block.
   logic [cste_pkg::MODE_W-1:0] cur_mode = cste_pkg::MODE_FCFS;
   logic [cste_pkg::QNT_W-1:0]  cur_qnt = 1;
   logic [cste_pkg::ARR_W-1:0]  arr_s[NPROC];
   logic [cste_pkg::BUR_W-1:0]  bur_s[NPROC];
   logic [cste_pkg::BUR_W-1:0]  rem_s[NPROC];
   logic [cste_pkg::PRI_W-1:0]  pri_s[NPROC];
   bit                          done_s[NPROC];
   int                          ord[NPROC];
   int                          loaded = 0;
   longint                      now;
   int                          emitted;

   function automatic void retire(int i);
      longint tat, wt;
      completion_type c;
      tat = now >= arr_s[i] ? now - arr_s[i] : 0;
      wt = tat >= bur_s[i] ? tat - bur_s[i] : 0;
      c.pidx = i[3:0];
      c.ct = now[20:0];
      c.wt = wt[19:0];
      c.tat = tat[20:0];
      c.last = 0;
      exp_buf[exp_wr % EXP_DEPTH] = c;
      exp_wr++;
      done_s[i] = 1;
      rem_s[i] = 0;
      emitted++;
   endfunction

   function automatic void schedule_batch();
      int n, k, j, v, p, best, first, i;
      longint d, q;
      int rq[NPROC];
      int rq_h, rq_n;
      n = loaded;
      now = 0;
      emitted = 0;
      rq_h = 0;
      rq_n = 0;
      for (k = 0; k < n; k++) done_s[k] = 0;
      for (k = 0; k < n; k++) begin
         v = k;
         j = k;
         while (j > 0 && arr_s[ord[j-1]] > arr_s[v]) begin
            ord[j] = ord[j-1];
            j--;
         end
         ord[j] = v;
      end
      case (cur_mode)
         cste_pkg::MODE_FCFS: begin
            for (k = 0; k < n; k++) begin
               i = ord[k];
               if (now < arr_s[i]) now = arr_s[i];
               now += bur_s[i];
               retire(i);
            end
         end
         cste_pkg::MODE_PRIO: begin
            while (emitted < n) begin
               best = n;
               first = n;
               for (k = 0; k < n; k++) begin
                  i = ord[k];
                  if (done_s[i]) continue;
                  if (first == n) first = i;
                  if (arr_s[i] > now) continue;
                  if (best == n || pri_s[i] > pri_s[best]) best = i;
               end
               if (best == n) begin
                  now = arr_s[first];
                  continue;
               end
               now += bur_s[best];
               retire(best);
            end
         end
         cste_pkg::MODE_SRTF: begin
            p = 0;
            while (emitted < n) begin
               best = n;
               while (p < n && arr_s[ord[p]] <= now) p++;
               for (k = 0; k < p; k++) begin
                  i = ord[k];
                  if (done_s[i]) continue;
                  if (best == n || rem_s[i] < rem_s[best]) best = i;
               end
               if (best == n) begin
                  now = arr_s[ord[p]];
                  continue;
               end
               d = rem_s[best];
               if (p < n && arr_s[ord[p]] - now < d) d = arr_s[ord[p]] - now;
               now += d;
               rem_s[best] = rem_s[best] - d[15:0];
               if (rem_s[best] == 0) retire(best);
            end
         end
         default: begin
            p = 0;
            q = (cur_qnt == 0) ? 1 : cur_qnt;
            while (emitted < n) begin
               while (p < n && arr_s[ord[p]] <= now) begin
                  rq[(rq_h + rq_n) % NPROC] = ord[p];
                  rq_n++;
                  p++;
               end
               if (rq_n == 0) begin
                  now = arr_s[ord[p]];
                  continue;
               end
               i = rq[rq_h];
               rq_h = (rq_h + 1) % NPROC;
               rq_n--;
               d = rem_s[i] < q ? rem_s[i] : q;
               now += d;
               rem_s[i] = rem_s[i] - d[15:0];
               while (p < n && arr_s[ord[p]] <= now) begin
                  rq[(rq_h + rq_n) % NPROC] = ord[p];
                  rq_n++;
                  p++;
               end
               if (rem_s[i] > 0) begin
                  rq[(rq_h + rq_n) % NPROC] = i;
                  rq_n++;
               end else begin
                  retire(i);
               end
            end
         end
      endcase
      if (emitted > 0) exp_buf[(exp_wr - 1) % EXP_DEPTH].last = 1;
      loaded = 0;
   endfunction

   function automatic void record_accepted(logic [15:0] a, logic [15:0] b,
                                           logic [7:0] pr, bit lst);
      if (loaded < NPROC) begin
         arr_s[loaded] = a;
         bur_s[loaded] = (b == 0) ? 16'd1 : b;
         rem_s[loaded] = bur_s[loaded];
         pri_s[loaded] = pr;
         loaded++;
      end
      if (lst) schedule_batch();
   endfunction

   function automatic int gap_len();
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Receiver side: random stalls, plus one long hold-off on request.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 0;
      end else if (hold_start && !hold_seen) begin
         hold_seen <= 1;
         rsp_hold <= 3000;
         rsp_tready <= 0;
      end else if (rsp_hold > 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_tready <= 0;
      end else begin
         rsp_tready <= quiet || ($urandom_range(0, 99) < 70) ||
                       ($urandom_range(0, 99) < 30);
      end
   end

   always @(posedge clock) begin
      completion_type e;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (exp_rd == exp_wr) begin
            $display("%0t: unexpected completion request %h last %b", $time,
                     rsp_tdata, rsp_tlast);
            errors++;
         end else begin
            e = exp_buf[exp_rd % EXP_DEPTH];
            exp_rd++;
            if (rsp_tdata[3:0] !== e.pidx) begin
               $display("%0t: process index expected %0d actual %0d", $time,
                        e.pidx, rsp_tdata[3:0]);
               errors++;
            end
            if (rsp_tdata[24:4] !== e.ct) begin
               $display("%0t: completion expected %0d actual %0d", $time,
                        e.ct, rsp_tdata[24:4]);
               errors++;
            end
            if (rsp_tdata[44:25] !== e.wt) begin
               $display("%0t: waiting expected %0d actual %0d", $time,
                        e.wt, rsp_tdata[44:25]);
               errors++;
            end
            if (rsp_tdata[65:45] !== e.tat) begin
               $display("%0t: turnaround expected %0d actual %0d", $time,
                        e.tat, rsp_tdata[65:45]);
               errors++;
            end
            if (rsp_tdata[71:66] !== 6'd0) begin
               $display("%0t: fill bits expected 0 actual %h", $time,
                        rsp_tdata[71:66]);
               errors++;
            end
            if (rsp_tlast !== e.last) begin
               $display("%0t: last flag expected %b actual %b", $time,
                        e.last, rsp_tlast);
               errors++;
            end
         end
      end
   end

   // Waits until every expected completion has left and the engine is quiet.
   task automatic drain();
      while (exp_rd != exp_wr) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] val);
      drain();
      csr_wr_en = 1;
      csr_index = idx;
      csr_wr_data = val;
      @(negedge clock);
      csr_wr_en = 0;
      if (idx == cste_pkg::CSR_QUANTUM) cur_qnt = val;
      else cur_mode = val[1:0];
   endtask

   task automatic set_policy(logic [cste_pkg::MODE_W-1:0] m, logic [15:0] q);
      write_csr(cste_pkg::CSR_POLICY, {14'd0, m});
      write_csr(cste_pkg::CSR_QUANTUM, q);
   endtask

   // Offers one record from a falling edge and returns after it is taken.
   task automatic send_record(logic [15:0] a, logic [15:0] b, logic [7:0] pr,
                              bit lst);
      int g;
      g = gap_len();
      repeat (g) @(negedge clock);
      req_tvalid = 1;
      req_tdata = {pr, b, a};
      req_tlast = lst;
      do @(posedge clock); while (!req_tready);
      record_accepted(a, b, pr, lst);
      items_sent++;
      @(negedge clock);
      req_tvalid = 0;
      req_tdata = 40'({$urandom, $urandom});
      req_tlast = 1'($urandom_range(0, 1));
   endtask

   row_type dir_rows[MAX_ROWS];
   int      n_rows = 0;

   task automatic add_row(bit s, logic [1:0] m, logic [15:0] q, logic [15:0] a,
                          logic [15:0] b, logic [7:0] pr, bit lst,
                          bit ty = 0, int ct = 0, int wt = 0, int tat = 0);
      row_type r;
      r.set_cfg = s;
      r.mode = m;
      r.qnt = q;
      r.arr = a;
      r.bur = b;
      r.pri = pr;
      r.last = lst;
      r.typed = ty;
      r.ct = ct;
      r.wt = wt;
      r.tat = tat;
      dir_rows[n_rows] = r;
      n_rows++;
   endtask

   task automatic random_batch(int n);
      int k, style, abase;
      logic [15:0] a, b;
      bit short_slices;
      style = $urandom_range(0, 3);
      abase = $urandom_range(0, 65535 - 200);
      short_slices = (cur_mode == cste_pkg::MODE_RR) && (cur_qnt < 256);
      for (k = 0; k < n; k++) begin
         case (style)
            0: a = 16'($urandom_range(0, 40));
            1: a = 16'(abase + $urandom_range(0, 200));
            2: a = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            default: a = 16'($urandom);
         endcase
         if (short_slices) b = 16'($urandom_range(0, 20));
         else if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
         else if ($urandom_range(0, 1)) b = 16'($urandom_range(1, 50));
         else b = 16'($urandom);
         send_record(a, b, 8'($urandom), k == n - 1);
      end
   endtask

   initial begin
      int k, n, ph;
      logic [1:0] m;
      logic [15:0] q;

      // Single-record runs whose results are obvious.
      add_row(1, cste_pkg::MODE_FCFS, 16'd1, 16'd0, 16'd5, 8'd0, 1, 1, 5, 0, 5);
      add_row(0, cste_pkg::MODE_FCFS, 16'd1, 16'hFFFF, 16'hFFFF, 8'hFF, 1, 1,
              131070, 0, 65535);
      // A zero burst counts as one tick.
      add_row(0, cste_pkg::MODE_FCFS, 16'd1, 16'd10, 16'd0, 8'd7, 1, 1, 11, 0, 1);
      add_row(1, cste_pkg::MODE_SRTF, 16'd1, 16'd0, 16'd8, 8'd1, 0);
      add_row(0, cste_pkg::MODE_SRTF, 16'd1, 16'd1, 16'd4, 8'd2, 0);
      add_row(0, cste_pkg::MODE_SRTF, 16'd1, 16'd2, 16'd9, 8'd3, 0);
      add_row(0, cste_pkg::MODE_SRTF, 16'd1, 16'd3, 16'd5, 8'd4, 1);
      add_row(1, cste_pkg::MODE_PRIO, 16'd1, 16'd0, 16'd3, 8'd1, 0);
      add_row(0, cste_pkg::MODE_PRIO, 16'd1, 16'd1, 16'd4, 8'd9, 0);
      add_row(0, cste_pkg::MODE_PRIO, 16'd1, 16'd1, 16'd4, 8'd200, 0);
      add_row(0, cste_pkg::MODE_PRIO, 16'd1, 16'd2, 16'd2, 8'd200, 1);
      // A zero slice behaves as a one-tick slice.
      add_row(1, cste_pkg::MODE_RR, 16'd0, 16'd0, 16'd3, 8'd0, 0);
      add_row(0, cste_pkg::MODE_RR, 16'd0, 16'd0, 16'd2, 8'd0, 1);
      // Idle gap in round robin before the late arrival.
      add_row(1, cste_pkg::MODE_RR, 16'd2, 16'd5, 16'd4, 8'd0, 0);
      add_row(0, cste_pkg::MODE_RR, 16'd2, 16'd0, 16'd3, 8'd0, 0);
      add_row(0, cste_pkg::MODE_RR, 16'd2, 16'd20, 16'd1, 8'd0, 1);
      add_row(1, cste_pkg::MODE_RR, 16'hFFFF, 16'd0, 16'hFFFF, 8'd0, 0);
      add_row(0, cste_pkg::MODE_RR, 16'hFFFF, 16'd0, 16'd1, 8'd0, 1);

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      for (k = 0; k < n_rows; k++) begin
         if (dir_rows[k].set_cfg) set_policy(dir_rows[k].mode, dir_rows[k].qnt);
         send_record(dir_rows[k].arr, dir_rows[k].bur, dir_rows[k].pri,
                     dir_rows[k].last);
         if (dir_rows[k].typed) begin
            exp_buf[(exp_wr - 1) % EXP_DEPTH].ct = cste_pkg::CT_W'(dir_rows[k].ct);
            exp_buf[(exp_wr - 1) % EXP_DEPTH].wt = cste_pkg::WT_W'(dir_rows[k].wt);
            exp_buf[(exp_wr - 1) % EXP_DEPTH].tat = cste_pkg::TAT_W'(dir_rows[k].tat);
         end
      end

      ph = 0;
      while (items_sent < TOTAL_ITEMS) begin
         case (ph % 8)
            0: begin m = cste_pkg::MODE_FCFS; q = 16'($urandom); end
            1: begin m = cste_pkg::MODE_SRTF; q = 16'($urandom); end
            2: begin m = cste_pkg::MODE_PRIO; q = 16'($urandom); end
            3: begin m = cste_pkg::MODE_RR; q = 16'd1; end
            4: begin m = cste_pkg::MODE_RR; q = 16'd0; end
            5: begin m = cste_pkg::MODE_RR; q = 16'hFFFF; end
            6: begin m = cste_pkg::MODE_RR; q = 16'($urandom_range(2, 12)); end
            default: begin
               m = 2'($urandom_range(0, 3));
               q = 16'($urandom_range(1, 65535));
            end
         endcase
         set_policy(m, q);
         quiet = (ph % 5 == 4);
         for (k = 0; k < 3 && items_sent < TOTAL_ITEMS; k++) begin
            // Now and then overfill the store so the extra records are dropped.
            if ($urandom_range(0, 7) == 0) n = $urandom_range(17, 20);
            else if ($urandom_range(0, 3) == 0) n = 16;
            else n = $urandom_range(1, 10);
            if (ph == 3 && k == 0) hold_start = 1;
            random_batch(n);
         end
         ph++;
      end
      quiet = 0;

      drain();
      repeat (200) @(posedge clock);
      if (errors == 0 && exp_rd == exp_wr)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

>>> cpu_schedule_timing_engine.f
sv/cste_pkg.sv
sv/cste_ctrl.sv
sv/cste_dp.sv
sv/cpu_schedule_timing_engine.sv
sv/cste_checker.sv
test/cpu_schedule_timing_engine_test.sv
